@@ src/cast_pkg.sv @@
// Shared types and constants for the CAN actuator status table.
// Used by cast_front, cast_queue, cast_back and can_actuator_status_table.
package cast_pkg;

   localparam int unsigned ID_W = 29;

   // Request selector codes
   localparam logic [1:0] REQ_FRAME  = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_STATUS_BASE = 2'd0;
   localparam logic [1:0] CSR_UID_BASE    = 2'd1;
   localparam logic [1:0] CSR_ADDR_MIN    = 2'd2;
   localparam logic [1:0] CSR_ADDR_MAX    = 2'd3;

   // Register reset values
   localparam logic [ID_W-1:0] STATUS_BASE_RST = 29'd256;
   localparam logic [ID_W-1:0] UID_BASE_RST    = 29'd512;
   localparam logic [7:0]      ADDR_MIN_RST    = 8'd1;
   localparam logic [7:0]      ADDR_MAX_RST    = 8'd16;

   // Frame kind codes reported in a result
   localparam logic [1:0] FK_NONE   = 2'd0;
   localparam logic [1:0] FK_STATUS = 2'd1;
   localparam logic [1:0] FK_UID    = 2'd2;

   localparam logic [3:0] UID_FRAME_LEN = 4'd8;
   localparam logic [4:0] CNT_MAX       = 5'd31;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STATUS,
      OP_UID,
      OP_LOOKUP,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0] status_base;
      logic [ID_W-1:0] uid_base;
      logic [7:0]      addr_min;
      logic [7:0]      addr_max;
   } cfg_type;

   // Classified command; idx is the table index (address - 1)
   typedef struct packed {
      op_type      op;
      logic [7:0]  idx;
      logic [63:0] data;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  frame_kind;
      logic        found;
      logic [7:0]  found_address;
      logic [7:0]  entry_flags;
      logic [15:0] motor_current;
      logic [31:0] entry_seen_ms;
      logic        is_online;
      logic [63:0] entry_uid;
      logic        entry_uid_known;
      logic [4:0]  online_count;
   } rsp_type;

endpackage

@@ src/cast_front.sv @@
// Front end of the status table: classifies one request into a command.
// Depends on cast_pkg (cfg_type, cmd_type, op and request codes).
module cast_front #(
   parameter int unsigned ENTRIES = 16
) (
   input  cast_pkg::cfg_type          cfg,
   input  logic [1:0]                 req_type,
   input  logic [cast_pkg::ID_W-1:0]  req_can_id,
   input  logic [3:0]                 req_frame_len,
   input  logic [63:0]                req_frame_data,
   input  logic [31:0]                req_now_ms,
   input  logic [63:0]                req_uid_key,
   input  logic [7:0]                 req_address,
   output cast_pkg::cmd_type          cmd
);

   // Return {in_window, offset}; the offset is below ENTRIES when in window
   function automatic logic [8:0] win_decode(input logic [cast_pkg::ID_W-1:0] id,
                                             input logic [cast_pkg::ID_W-1:0] base);
      logic [cast_pkg::ID_W-1:0] off;
      logic                      hit;
      off = id - base;
      hit = (id >= base) && (off < cast_pkg::ID_W'(ENTRIES));
      return {hit, off[7:0]};
   endfunction

   logic [8:0] stat_win;
   logic [8:0] uid_win;
   logic       stat_ok;
   logic       uid_ok;
   logic       read_ok;

   assign stat_win = win_decode(req_can_id, cfg.status_base);
   assign uid_win  = win_decode(req_can_id, cfg.uid_base);

   assign stat_ok = (stat_win[7:0] != 8'd0) && (stat_win[7:0] >= cfg.addr_min)
                    && (stat_win[7:0] <= cfg.addr_max);
   assign uid_ok  = (uid_win[7:0] != 8'd0) && (uid_win[7:0] >= cfg.addr_min)
                    && (uid_win[7:0] <= cfg.addr_max)
                    && (req_frame_len == cast_pkg::UID_FRAME_LEN);
   assign read_ok = (req_address != 8'd0) && (req_address <= 8'(ENTRIES))
                    && (req_address >= cfg.addr_min) && (req_address <= cfg.addr_max);

   always_comb begin
      cmd.op   = cast_pkg::OP_NONE;
      cmd.idx  = 8'd0;
      cmd.data = req_frame_data;
      cmd.now  = req_now_ms;
      case (req_type)
         cast_pkg::REQ_FRAME: begin
            // status window wins; an invalid address there drops the frame
            if (stat_win[8]) begin
               if (stat_ok) begin
                  cmd.op  = cast_pkg::OP_STATUS;
                  cmd.idx = stat_win[7:0] - 8'd1;
               end
            end else if (uid_win[8] && uid_ok) begin
               cmd.op  = cast_pkg::OP_UID;
               cmd.idx = uid_win[7:0] - 8'd1;
            end
         end
         cast_pkg::REQ_LOOKUP: begin
            cmd.op   = cast_pkg::OP_LOOKUP;
            cmd.data = req_uid_key;
         end
         cast_pkg::REQ_READ: begin
            if (read_ok) begin
               cmd.op  = cast_pkg::OP_READ;
               cmd.idx = req_address - 8'd1;
            end
         end
         default: begin
            cmd.op = cast_pkg::OP_NONE;
         end
      endcase
   end

endmodule

@@ src/cast_queue.sv @@
// Two-slot command queue between front and back of the status table.
// Depends on cast_pkg (cmd_type).
module cast_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cast_pkg::cmd_type push_cmd,
   input  logic              pop,
   output cast_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   cast_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/cast_back.sv @@
// Back end of the status table: entry memories, UID scan and result register.
// Depends on cast_pkg (cmd_type, rsp_type, state_type, codes).
module cast_back #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cast_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   output cast_pkg::rsp_type rsp
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   // Entry memories; per-entry valid bits gate reads of unwritten entries
   logic [23:0] stat_mem [ENTRIES];
   logic [31:0] seen_mem [ENTRIES];
   logic [63:0] uid_mem  [ENTRIES];

   cast_pkg::state_type state_ff;
   cast_pkg::state_type state_in;
   cast_pkg::cmd_type   cmd_ff;
   cast_pkg::cmd_type   cmd_in;
   cast_pkg::rsp_type   rsp_ff;
   cast_pkg::rsp_type   rsp_in;
   cast_pkg::rsp_type   report;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [IDX_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    scan_in;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [IDX_W-1:0]    rd_addr_in;
   logic [IDX_W-1:0]    widx;
   logic [23:0]         stat_q;
   logic [31:0]         seen_q;
   logic [63:0]         uid_q;
   logic [ENTRIES-1:0]  online_ff;
   logic [ENTRIES-1:0]  stat_ok_ff;
   logic [ENTRIES-1:0]  uid_ok_ff;
   logic [4:0]          cnt_ff;
   logic [4:0]          cnt_in;
   logic                wr_stat;
   logic                wr_uid;
   logic                wr_seen;
   logic                scan_hit;

   assign widx     = cmd_ff.idx[IDX_W-1:0];
   assign scan_hit = uid_ok_ff[rd_idx_ff] && (uid_q == cmd_ff.data);

   // Entry fields as read last cycle
   always_comb begin
      report                 = '0;
      report.found           = 1'b1;
      report.found_address   = 8'(rd_idx_ff) + 8'd1;
      report.entry_flags     = stat_ok_ff[rd_idx_ff] ? stat_q[23:16] : 8'd0;
      report.motor_current   = stat_ok_ff[rd_idx_ff] ? stat_q[15:0] : 16'd0;
      report.entry_seen_ms   = online_ff[rd_idx_ff] ? seen_q : 32'd0;
      report.is_online       = online_ff[rd_idx_ff];
      report.entry_uid       = uid_ok_ff[rd_idx_ff] ? uid_q : 64'd0;
      report.entry_uid_known = uid_ok_ff[rd_idx_ff];
      report.online_count    = cnt_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cast_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = cast_pkg::ST_EXEC;
            end
         end
         cast_pkg::ST_EXEC: begin
            case (cmd_ff.op)
               cast_pkg::OP_LOOKUP: state_in = cast_pkg::ST_SCAN;
               cast_pkg::OP_READ:   state_in = cast_pkg::ST_REPORT;
               default:             state_in = cast_pkg::ST_IDLE;
            endcase
         end
         cast_pkg::ST_REPORT: begin
            state_in = cast_pkg::ST_IDLE;
         end
         cast_pkg::ST_SCAN: begin
            if (scan_hit || (scan_ff == LAST)) begin
               state_in = cast_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cast_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop               = 1'b0;
      cmd_in              = cmd_ff;
      rsp_valid_in        = 1'b0;
      wr_stat             = 1'b0;
      wr_uid              = 1'b0;
      wr_seen             = 1'b0;
      scan_in             = scan_ff;
      rd_addr_in          = rd_idx_ff;
      cnt_in              = cnt_ff;
      rsp_in              = '0;
      rsp_in.online_count = cnt_ff;
      case (state_ff)
         cast_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
            end
         end
         cast_pkg::ST_EXEC: begin
            case (cmd_ff.op)
               cast_pkg::OP_STATUS: begin
                  wr_stat           = 1'b1;
                  wr_seen           = 1'b1;
                  rsp_valid_in      = 1'b1;
                  rsp_in.frame_kind = cast_pkg::FK_STATUS;
               end
               cast_pkg::OP_UID: begin
                  wr_uid            = 1'b1;
                  wr_seen           = 1'b1;
                  rsp_valid_in      = 1'b1;
                  rsp_in.frame_kind = cast_pkg::FK_UID;
               end
               cast_pkg::OP_LOOKUP: begin
                  rd_addr_in = '0;
                  scan_in    = '0;
               end
               cast_pkg::OP_READ: begin
                  rd_addr_in = widx;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
            // count a newly online entry; entries never drop out
            if (wr_seen && !online_ff[widx] && (cnt_ff != cast_pkg::CNT_MAX)) begin
               cnt_in = cnt_ff + 5'd1;
            end
            rsp_in.online_count = cnt_in;
         end
         cast_pkg::ST_REPORT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = report;
         end
         cast_pkg::ST_SCAN: begin
            if (scan_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = report;
            end else if (scan_ff == LAST) begin
               rsp_valid_in = 1'b1;
            end else begin
               scan_in    = scan_ff + IDX_W'(1);
               rd_addr_in = scan_ff + IDX_W'(1);
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cast_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 5'd0;
         online_ff    <= '0;
         stat_ok_ff   <= '0;
         uid_ok_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (wr_seen) begin
            online_ff[widx] <= 1'b1;
         end
         if (wr_stat) begin
            stat_ok_ff[widx] <= 1'b1;
         end
         if (wr_uid) begin
            uid_ok_ff[widx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      scan_ff   <= scan_in;
      rsp_ff    <= rsp_in;
      rd_idx_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_stat) begin
         stat_mem[widx] <= {cmd_ff.data[63:56], cmd_ff.data[55:40]};
      end
      if (wr_uid) begin
         uid_mem[widx] <= cmd_ff.data;
      end
      if (wr_seen) begin
         seen_mem[widx] <= cmd_ff.now;
      end
      stat_q <= stat_mem[rd_addr_in];
      seen_q <= seen_mem[rd_addr_in];
      uid_q  <= uid_mem[rd_addr_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ src/can_actuator_status_table.sv @@
// CAN actuator status table top: csr registers, front classifier, queue and back end.
// A request is queued, then the back end pops it while idle and executes it; a read then
// reports the entry it read, and a lookup scans entries from index 0 to a UID hit or the last.
// The back end alone sets the rate, results are never held off; the queue takes items while
// it has room. Sync reset clears entries, count and registers.
// Depends on cast_pkg, cast_front, cast_queue and cast_back.
module can_actuator_status_table #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // csr write port
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [cast_pkg::ID_W-1:0] csr_wdata,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_type,
   input  logic [cast_pkg::ID_W-1:0] req_can_id,
   input  logic [3:0]                req_frame_len,
   input  logic [63:0]               req_frame_data,
   input  logic [31:0]               req_now_ms,
   input  logic [63:0]               req_uid_key,
   input  logic [7:0]                req_address,
   // result channel, one-cycle strobe, no back-pressure
   output logic                      rsp_valid,
   output logic [1:0]                rsp_frame_kind,
   output logic                      rsp_found,
   output logic [7:0]                rsp_found_address,
   output logic [7:0]                rsp_entry_flags,
   output logic [15:0]               rsp_motor_current,
   output logic [31:0]               rsp_entry_seen_ms,
   output logic                      rsp_is_online,
   output logic [63:0]               rsp_entry_uid,
   output logic                      rsp_entry_uid_known,
   output logic [4:0]                rsp_online_count
);

   cast_pkg::cfg_type cfg_ff;
   cast_pkg::cfg_type cfg_in;
   cast_pkg::cmd_type front_cmd;
   cast_pkg::cmd_type q_head;
   cast_pkg::rsp_type rsp;
   logic              push;
   logic              q_pop;
   logic              q_empty;
   logic              q_full;

   // Update one csr per write; software must write only while the block is idle, which the block does not enforce
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cast_pkg::CSR_STATUS_BASE: cfg_in.status_base = csr_wdata;
            cast_pkg::CSR_UID_BASE:    cfg_in.uid_base    = csr_wdata;
            cast_pkg::CSR_ADDR_MIN:    cfg_in.addr_min    = csr_wdata[7:0];
            cast_pkg::CSR_ADDR_MAX:    cfg_in.addr_max    = csr_wdata[7:0];
            default:                   cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.status_base <= cast_pkg::STATUS_BASE_RST;
         cfg_ff.uid_base    <= cast_pkg::UID_BASE_RST;
         cfg_ff.addr_min    <= cast_pkg::ADDR_MIN_RST;
         cfg_ff.addr_max    <= cast_pkg::ADDR_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept an item whenever the queue has room
   assign busy = q_full;
   assign push = start && !q_full;

   // Classify the request into a table command
   cast_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .cfg            (cfg_ff),
      .req_type       (req_type),
      .req_can_id     (req_can_id),
      .req_frame_len  (req_frame_len),
      .req_frame_data (req_frame_data),
      .req_now_ms     (req_now_ms),
      .req_uid_key    (req_uid_key),
      .req_address    (req_address),
      .cmd            (front_cmd)
   );

   // Hold classified commands until the back end is free
   cast_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Update entries, scan UIDs and drive the result register
   cast_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_frame_kind      = rsp.frame_kind;
   assign rsp_found           = rsp.found;
   assign rsp_found_address   = rsp.found_address;
   assign rsp_entry_flags     = rsp.entry_flags;
   assign rsp_motor_current   = rsp.motor_current;
   assign rsp_entry_seen_ms   = rsp.entry_seen_ms;
   assign rsp_is_online       = rsp.is_online;
   assign rsp_entry_uid       = rsp.entry_uid;
   assign rsp_entry_uid_known = rsp.entry_uid_known;
   assign rsp_online_count    = rsp.online_count;

`ifndef SYNTHESIS
   // A stored frame never reports an entry
   a_frame_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind != cast_pkg::FK_NONE) |->
         !rsp_found && (rsp_found_address == 8'd0))
      else $error("frame result reports an entry");

   // A reported entry carries an address inside the table
   a_found_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (rsp_found_address != 8'd0) && (rsp_found_address <= 8'(ENTRIES)))
      else $error("found address outside table");

   // An entry that never sent a frame has no timestamp
   a_offline_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_online |-> (rsp_entry_seen_ms == 32'd0))
      else $error("offline entry reports a timestamp");

   // Entries never go offline, so the tracked count never drops
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2) |->
         rsp_online_count >= $past(rsp_online_count))
      else $error("online count decreased");
`endif

endmodule

@@ sim/can_actuator_status_table_tb.sv @@
// Self-checking testbench for the CAN actuator status table.
// Drives items on the start/busy port, predicts every result from a shadow table and
// checks it field by field; depends on cast_pkg and can_actuator_status_table.
`timescale 1ns / 1ps

module can_actuator_status_table_tb;

   localparam int unsigned ID_W          = cast_pkg::ID_W;
   localparam int unsigned ENTRIES       = 16;
   localparam int unsigned RESET_CYCLES  = 12;
   // Longest path through the block is a lookup miss, which scans every entry
   localparam int unsigned SETTLE_CYCLES = ENTRIES + 8;
   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned POOL_SIZE     = 6;

   // Selector code the block must treat as a no-op
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] can_id;
      logic [3:0]      len;
      logic [63:0]     data;
      logic [31:0]     now;
      logic [63:0]     key;
      logic [7:0]      address;
   } table_req_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_wr_en;
   logic [1:0]      csr_index;
   logic [ID_W-1:0] csr_wdata;
   logic            start;
   logic            busy;
   logic [1:0]      req_type;
   logic [ID_W-1:0] req_can_id;
   logic [3:0]      req_frame_len;
   logic [63:0]     req_frame_data;
   logic [31:0]     req_now_ms;
   logic [63:0]     req_uid_key;
   logic [7:0]      req_address;
   logic            rsp_valid;
   logic [1:0]      rsp_frame_kind;
   logic            rsp_found;
   logic [7:0]      rsp_found_address;
   logic [7:0]      rsp_entry_flags;
   logic [15:0]     rsp_motor_current;
   logic [31:0]     rsp_entry_seen_ms;
   logic            rsp_is_online;
   logic [63:0]     rsp_entry_uid;
   logic            rsp_entry_uid_known;
   logic [4:0]      rsp_online_count;

   // Shadow copy of the registers and of the actuator table
   logic [ID_W-1:0] cfg_status_base;
   logic [ID_W-1:0] cfg_uid_base;
   logic [7:0]      cfg_addr_min;
   logic [7:0]      cfg_addr_max;
   logic [7:0]      sh_flags     [ENTRIES];
   logic [15:0]     sh_current   [ENTRIES];
   logic [31:0]     sh_seen      [ENTRIES];
   logic            sh_online    [ENTRIES];
   logic [63:0]     sh_uid       [ENTRIES];
   logic            sh_uid_known [ENTRIES];

   // Results predicted but not yet seen on the rsp port, oldest first
   cast_pkg::rsp_type replies_due[$];
   logic [63:0]       uid_pool [POOL_SIZE];
   int unsigned       sender_idle_pct;
   int unsigned       faults;
   int unsigned       items_sent;
   int unsigned       replies_checked;
   int unsigned       frames_stored;
   int unsigned       lookup_hits;
   int unsigned       settings_used;
   int unsigned       cycles;

   can_actuator_status_table #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_can_id         (req_can_id),
      .req_frame_len      (req_frame_len),
      .req_frame_data     (req_frame_data),
      .req_now_ms         (req_now_ms),
      .req_uid_key        (req_uid_key),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_found          (rsp_found),
      .rsp_found_address  (rsp_found_address),
      .rsp_entry_flags    (rsp_entry_flags),
      .rsp_motor_current  (rsp_motor_current),
      .rsp_entry_seen_ms  (rsp_entry_seen_ms),
      .rsp_is_online      (rsp_is_online),
      .rsp_entry_uid      (rsp_entry_uid),
      .rsp_entry_uid_known(rsp_entry_uid_known),
      .rsp_online_count   (rsp_online_count)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow table
   // ---------------------------------------------------------------------------

   // Tell whether id falls in the ENTRIES-wide window starting at base; hand back
   // the offset, which is also the address the frame names.
   function automatic bit in_window(input logic [ID_W-1:0] id, input logic [ID_W-1:0] base,
                                    output int unsigned off);
      off = 0;
      if (id < base)
         return 1'b0;
      off = 32'(id) - 32'(base);
      return off < ENTRIES;
   endfunction

   // Address 0 and anything outside [addr_min, addr_max] never gets stored
   function automatic bit frame_address_ok(input int unsigned off);
      return off >= 1 && off >= cfg_addr_min && off <= cfg_addr_max;
   endfunction

   // Fill the entry fields of a result from the shadow entry at address a
   function automatic cast_pkg::rsp_type entry_view(input cast_pkg::rsp_type base_rsp,
                                                    input int unsigned a);
      cast_pkg::rsp_type r;
      r = base_rsp;
      r.found           = 1'b1;
      r.found_address   = a[7:0];
      r.entry_flags     = sh_flags[a-1];
      r.motor_current   = sh_current[a-1];
      r.entry_seen_ms   = sh_seen[a-1];
      r.is_online       = sh_online[a-1];
      r.entry_uid       = sh_uid[a-1];
      r.entry_uid_known = sh_uid_known[a-1];
      return r;
   endfunction

   // Apply one accepted item to the shadow table and return the result it causes
   function automatic cast_pkg::rsp_type apply_to_shadow_table(input table_req_type rq);
      cast_pkg::rsp_type r;
      int unsigned       off;
      int unsigned       live;
      bit                hit;
      r    = '0;
      live = 0;
      hit  = 1'b0;
      case (rq.kind)
         cast_pkg::REQ_FRAME: begin
            // Status window wins over an overlapping UID window, even when the
            // status address turns out invalid
            if (in_window(rq.can_id, cfg_status_base, off)) begin
               if (frame_address_ok(off)) begin
                  sh_flags[off-1]   = rq.data[63:56];
                  sh_current[off-1] = rq.data[55:40];
                  sh_seen[off-1]    = rq.now;
                  sh_online[off-1]  = 1'b1;
                  r.frame_kind      = cast_pkg::FK_STATUS;
                  frames_stored++;
               end
            end else if (in_window(rq.can_id, cfg_uid_base, off) && frame_address_ok(off)
                         && rq.len == cast_pkg::UID_FRAME_LEN) begin
               sh_uid[off-1]       = rq.data;
               sh_uid_known[off-1] = 1'b1;
               sh_seen[off-1]      = rq.now;
               sh_online[off-1]    = 1'b1;
               r.frame_kind        = cast_pkg::FK_UID;
               frames_stored++;
            end
         end
         cast_pkg::REQ_LOOKUP: begin
            // First known UID that matches wins
            for (int i = 0; i < ENTRIES && !hit; i++) begin
               if (sh_uid_known[i] && sh_uid[i] == rq.key) begin
                  r   = entry_view(r, i + 1);
                  hit = 1'b1;
                  lookup_hits++;
               end
            end
         end
         cast_pkg::REQ_READ: begin
            if (rq.address >= 1 && rq.address <= ENTRIES && rq.address >= cfg_addr_min
                && rq.address <= cfg_addr_max)
               r = entry_view(r, 32'(rq.address));
         end
         default: ;
      endcase
      for (int i = 0; i < ENTRIES; i++)
         if (sh_online[i])
            live++;
      r.online_count = (live > cast_pkg::CNT_MAX) ? cast_pkg::CNT_MAX : live[4:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      cast_pkg::rsp_type want;
      if (rsp_valid === 1'b1) begin
         if (replies_due.size() == 0) begin
            $error("result strobe with no item outstanding");
            faults++;
         end else begin
            want = replies_due.pop_front();
            check_field("frame_kind",      64'(want.frame_kind),  64'(rsp_frame_kind));
            check_field("found",           64'(want.found),       64'(rsp_found));
            check_field("found_address",   64'(want.found_address),
                        64'(rsp_found_address));
            check_field("entry_flags",     64'(want.entry_flags), 64'(rsp_entry_flags));
            check_field("motor_current",   64'(want.motor_current),
                        64'(rsp_motor_current));
            check_field("entry_seen_ms",   64'(want.entry_seen_ms),
                        64'(rsp_entry_seen_ms));
            check_field("is_online",       64'(want.is_online),   64'(rsp_is_online));
            check_field("entry_uid",       want.entry_uid,        rsp_entry_uid);
            check_field("entry_uid_known", 64'(want.entry_uid_known),
                        64'(rsp_entry_uid_known));
            check_field("online_count",    64'(want.online_count),
                        64'(rsp_online_count));
            replies_checked++;
         end
      end
   end

   // Watchdog: end a hung run
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------------------

   function automatic table_req_type make_item(input logic [1:0] kind,
                                               input logic [ID_W-1:0] id,
                                               input logic [3:0] len, input logic [63:0] data,
                                               input logic [31:0] now, input logic [63:0] key,
                                               input logic [7:0] address);
      table_req_type rq;
      rq.kind    = kind;
      rq.can_id  = id;
      rq.len     = len;
      rq.data    = data;
      rq.now     = now;
      rq.key     = key;
      rq.address = address;
      return rq;
   endfunction

   // Build a random item aimed at the current windows most of the time, so that
   // frames land, UIDs repeat and lookups hit; the rest is plain noise.
   function automatic table_req_type random_item();
      table_req_type   rq;
      int unsigned     pick;
      logic [ID_W-1:0] base;
      pick       = $urandom_range(99);
      rq.kind    = (pick < 50) ? cast_pkg::REQ_FRAME : (pick < 70) ? cast_pkg::REQ_LOOKUP :
                   (pick < 95) ? cast_pkg::REQ_READ : REQ_UNUSED;
      rq.can_id  = ID_W'($urandom);
      rq.len     = 4'($urandom_range(0, 8));
      rq.data    = {$urandom, $urandom};
      rq.now     = $urandom;
      rq.key     = {$urandom, $urandom};
      rq.address = 8'($urandom_range(0, 255));
      case (rq.kind)
         cast_pkg::REQ_FRAME: begin
            pick = $urandom_range(99);
            if (pick < 85) begin
               base = (pick < 45) ? cfg_status_base : cfg_uid_base;
               // offsets -1 .. ENTRIES hit both edges of the window
               rq.can_id = base + ID_W'($urandom_range(0, ENTRIES + 1)) - 1'b1;
               if ($urandom_range(99) < 70)
                  rq.len = cast_pkg::UID_FRAME_LEN;
               if ($urandom_range(1) == 1)
                  rq.data = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
         end
         cast_pkg::REQ_LOOKUP: begin
            if ($urandom_range(99) < 65)
               rq.key = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         cast_pkg::REQ_READ: begin
            if ($urandom_range(99) < 70)
               rq.address = 8'($urandom_range(0, ENTRIES + 1));
         end
         default: ;
      endcase
      return rq;
   endfunction

   // Present one item and hold it until the block takes it. Start stays high on
   // return; the next call or wait_for_replies decides whether it drops.
   task automatic send_item(input table_req_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= rq.kind;
      req_can_id     <= rq.can_id;
      req_frame_len  <= rq.len;
      req_frame_data <= rq.data;
      req_now_ms     <= rq.now;
      req_uid_key    <= rq.key;
      req_address    <= rq.address;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      replies_due.push_back(apply_to_shadow_table(rq));
      items_sent++;
   endtask

   // Drop start, wait out every outstanding result, then let the block settle
   task automatic wait_for_replies();
      start <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] index, input logic [ID_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all four registers back to back; only call with the block idle
   task automatic program_registers(input logic [ID_W-1:0] status_base,
                                    input logic [ID_W-1:0] uid_base,
                                    input logic [7:0] addr_min, input logic [7:0] addr_max);
      put_reg(cast_pkg::CSR_STATUS_BASE, status_base);
      put_reg(cast_pkg::CSR_UID_BASE,    uid_base);
      put_reg(cast_pkg::CSR_ADDR_MIN,    {{(ID_W-8){1'b0}}, addr_min});
      put_reg(cast_pkg::CSR_ADDR_MAX,    {{(ID_W-8){1'b0}}, addr_max});
      csr_wr_en       <= 1'b0;
      cfg_status_base  = status_base;
      cfg_uid_base     = uid_base;
      cfg_addr_min     = addr_min;
      cfg_addr_max     = addr_max;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Fresh table: reads of every kind of address, a lookup with nothing known
   // and the unused selector
   task automatic test_reset_state();
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd0));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd1));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd16));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd17));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd255));
      send_item(make_item(cast_pkg::REQ_LOOKUP, '0, '0, '0, '0, 64'd0, '0));
      send_item(make_item(REQ_UNUSED, '1, 4'd8, '1, '1, '1, '1));
   endtask

   // Frame classification at default windows: status, UID, bad lengths,
   // address zero, out of window and the top identifier
   task automatic test_frame_kinds();
      // status frame length is never checked
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd257, 4'd0, '1, 32'hFFFF_FFFF, '0, '0));
      // address zero inside the status window: ignored, not tried as UID
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd256, 4'd8, 64'h5A5A, 32'd7, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd271, 4'd3, 64'h1234_5678_9ABC_DEF0,
                          32'd0, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd255, 4'd8, '1, 32'd9, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd514, 4'd8, 64'h0123_4567_89AB_CDEF,
                          32'd11, '0, '0));
      // UID frame shorter than eight bytes
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd515, 4'd7, 64'hDEAD_BEEF, 32'd12, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd528, 4'd8, '1, 32'd13, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd512, 4'd8, '1, 32'd14, '0, '0));
      send_item(make_item(cast_pkg::REQ_FRAME, '1, 4'd8, '1, 32'd15, '0, '0));
      // same UID on a second entry: lookups must still report the first
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd516, 4'd8, 64'h0123_4567_89AB_CDEF,
                          32'd16, '0, '0));
      // UID of zero on an entry that is already online from a status frame
      send_item(make_item(cast_pkg::REQ_FRAME, 29'd513, 4'd8, 64'd0, 32'd17, '0, '0));
   endtask

   // Lookups (duplicate hit, zero UID, miss) and reads of populated entries
   task automatic test_query_paths();
      send_item(make_item(cast_pkg::REQ_LOOKUP, '0, '0, '0, '0, 64'h0123_4567_89AB_CDEF, '0));
      send_item(make_item(cast_pkg::REQ_LOOKUP, '0, '0, '0, '0, 64'd0, '0));
      send_item(make_item(cast_pkg::REQ_LOOKUP, '0, '0, '0, '0, '1, '0));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd1));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd15));
      send_item(make_item(cast_pkg::REQ_READ, '0, '0, '0, '0, '0, 8'd4));
   endtask

   // Walk extreme register settings, each followed by a burst of random items
   task automatic test_register_extremes(input int unsigned per_setting);
      logic [ID_W-1:0] sbase [8];
      logic [ID_W-1:0] ubase [8];
      logic [7:0]      amin  [8];
      logic [7:0]      amax  [8];
      // adjacent windows at zero, full address range
      sbase[0] = 29'd0;         ubase[0] = 29'd16;          amin[0] = 8'd1;   amax[0] = 8'd255;
      // identical windows: status must win
      sbase[1] = 29'd1000;      ubase[1] = 29'd1000;        amin[1] = 8'd1;   amax[1] = 8'd16;
      // half overlap, narrow address range
      sbase[2] = 29'd1000;      ubase[2] = 29'd1008;        amin[2] = 8'd2;   amax[2] = 8'd12;
      // windows at the top of the identifier space
      sbase[3] = 29'h1FFF_FFFF; ubase[3] = 29'h1FFF_FFF0;   amin[3] = 8'd8;   amax[3] = 8'd8;
      // empty address range
      sbase[4] = 29'd300;       ubase[4] = 29'd600;         amin[4] = 8'd255; amax[4] = 8'd1;
      sbase[5] = 29'd256;       ubase[5] = 29'd512;         amin[5] = 8'd1;   amax[5] = 8'd1;
      sbase[6] = 29'd256;       ubase[6] = 29'd512;         amin[6] = 8'd255; amax[6] = 8'd255;
      sbase[7] = cast_pkg::STATUS_BASE_RST; ubase[7] = cast_pkg::UID_BASE_RST;
      amin[7] = cast_pkg::ADDR_MIN_RST;     amax[7] = cast_pkg::ADDR_MAX_RST;
      for (int s = 0; s < 8; s++) begin
         wait_for_replies();
         program_registers(sbase[s], ubase[s], amin[s], amax[s]);
         repeat (per_setting) send_item(random_item());
      end
   endtask

   // Long random run; re-program the registers every so often and now and then
   // hold the sender until every result is back
   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
      logic [ID_W-1:0] sbase;
      logic [ID_W-1:0] ubase;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 160 == 159) begin
            wait_for_replies();
            sbase = ($urandom_range(2) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 2047));
            case ($urandom_range(2))
               0:       ubase = sbase + ID_W'($urandom_range(0, 31));
               1:       ubase = ID_W'($urandom_range(0, 2047));
               default: ubase = ID_W'($urandom);
            endcase
            program_registers(sbase, ubase,
                              ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                       : 8'($urandom_range(1, 4)),
                              ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                       : 8'($urandom_range(12, 16)));
         end else if ($urandom_range(63) == 0) begin
            wait_for_replies();
         end
         send_item(random_item());
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= cast_pkg::CSR_STATUS_BASE;
      csr_wdata      <= '0;
      start          <= 1'b0;
      req_type       <= cast_pkg::REQ_FRAME;
      req_can_id     <= '0;
      req_frame_len  <= '0;
      req_frame_data <= '0;
      req_now_ms     <= '0;
      req_uid_key    <= '0;
      req_address    <= '0;

      // Shadow state matches what reset leaves behind
      cfg_status_base = cast_pkg::STATUS_BASE_RST;
      cfg_uid_base    = cast_pkg::UID_BASE_RST;
      cfg_addr_min    = cast_pkg::ADDR_MIN_RST;
      cfg_addr_max    = cast_pkg::ADDR_MAX_RST;
      for (int i = 0; i < ENTRIES; i++) begin
         sh_flags[i]     = '0;
         sh_current[i]   = '0;
         sh_seen[i]      = '0;
         sh_online[i]    = 1'b0;
         sh_uid[i]       = '0;
         sh_uid_known[i] = 1'b0;
      end
      uid_pool[0] = '0;
      uid_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         uid_pool[i] = {$urandom, $urandom};
      faults          = 0;
      items_sent      = 0;
      replies_checked = 0;
      frames_stored   = 0;
      lookup_hits     = 0;
      settings_used   = 0;
      sender_idle_pct = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_frame_kinds();
      test_query_paths();
      sender_idle_pct = 15;
      test_register_extremes(40);
      test_random_traffic(15, 480);
      test_random_traffic(63, 480);
      test_random_traffic(0, 480);
      wait_for_replies();

      $display("Run covered %0d items over %0d register settings: %0d frames stored,",
               items_sent, settings_used, frames_stored);
      $display("%0d lookup hits, %0d results checked, %0d field mismatches",
               lookup_hits, replies_checked, faults);
      if (faults == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
